// ----- rtl/stepper_tone_head_sweeper_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper assertion macros
// Concurrent assertion wrappers used by the RTL of the sweeper unit.
// ---------------------------------------------------------------------------
`ifndef STEPPER_TONE_HEAD_SWEEPER_UNIT_DEFINES_SVH
`define STEPPER_TONE_HEAD_SWEEPER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define STHS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STHS_ASSERT(lbl, clk, rst, prop, msg)
`define STHS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/sths_pkg.sv -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper package
// Widths, reset values, register indexes and controller interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sths_pkg;

  localparam int RATE_W = 20;
  localparam int TONE_W = 8;
  localparam int CMP_W  = 16;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(15625);
  localparam logic [POS_W-1:0]  LIMIT_RESET = POS_W'(78);
  localparam logic [CNT_W-1:0]  DIV_LAST    = CNT_W'(RATE_W - 1);

  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tone;
    logic tone_zero;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/sths_ifs.sv -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper channels
// Valid/ready interfaces for the item input and the result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sths_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [sths_pkg::TONE_W-1:0]  tone;

  modport source (output valid, output action, output tone, input ready);
  modport sink   (input valid, input action, input tone, output ready);
endinterface

interface sths_out_if;
  logic                         valid;
  logic                         ready;
  logic                         step_pulse;
  logic                         moving_backward;
  logic [sths_pkg::POS_W-1:0]   head_position;
  logic                         playing;

  modport source (output valid, output step_pulse, output moving_backward,
                  output head_position, output playing, input ready);
  modport sink   (input valid, input step_pulse, input moving_backward,
                  input head_position, input playing, output ready);
endinterface

// ----- rtl/sths_datapath.sv -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper datapath
// Configuration registers, radix-2 period divider, tick timer, head stepper
// and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sths_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sths_pkg::ctrl_cmd_t           cmd,
  output sths_pkg::ctrl_stat_t          stat,
  input  logic                          in_action,
  input  logic [sths_pkg::TONE_W-1:0]   in_tone,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_step_pulse,
  output logic                          out_moving_backward,
  output logic [sths_pkg::POS_W-1:0]    out_head_position,
  output logic                          out_playing,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sths_pkg::ADDR_W-1:0]   paddr,
  input  logic [sths_pkg::DATA_W-1:0]   pwdata,
  output logic [sths_pkg::DATA_W-1:0]   prdata
);

  logic [sths_pkg::RATE_W-1:0] prescaled_rate;
  logic [sths_pkg::POS_W-1:0]  travel_limit;
  logic [sths_pkg::CMP_W-1:0]  compare_value;
  logic [sths_pkg::CMP_W-1:0]  tick_count;
  logic [sths_pkg::POS_W-1:0]  position;
  logic                        backward;
  logic                        enabled;

  logic [sths_pkg::TONE_W-1:0] divisor;
  logic [sths_pkg::TONE_W-1:0] remainder;
  logic [sths_pkg::RATE_W-1:0] quotient;
  logic                        tone_zero;

  logic                        cfg_write;
  logic                        reg_index;
  logic [sths_pkg::TONE_W:0]   rem_shift;
  logic                        rem_fits;
  logic [sths_pkg::TONE_W:0]   rem_diff;
  logic [sths_pkg::RATE_W-1:0] quot_minus;
  logic [sths_pkg::CMP_W-1:0]  period;
  logic                        tick_match;
  logic                        do_step;
  logic [sths_pkg::POS_W-1:0]  pos_stepped;
  logic [sths_pkg::POS_W-1:0]  position_next;
  logic                        backward_next;
  logic                        enabled_next;
  logic                        tick_load;

  assign cfg_write = psel && penable && pwrite;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaled_rate <= sths_pkg::RATE_RESET;
      travel_limit   <= sths_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        sths_pkg::REG_RATE:  prescaled_rate <= pwdata[sths_pkg::RATE_W-1:0];
        sths_pkg::REG_LIMIT: travel_limit   <= pwdata[sths_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      sths_pkg::REG_RATE:  prdata = sths_pkg::DATA_W'(prescaled_rate);
      sths_pkg::REG_LIMIT: prdata = sths_pkg::DATA_W'(travel_limit);
      default:             prdata = '0;
    endcase
  end

  assign rem_shift = {remainder, quotient[sths_pkg::RATE_W-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign rem_fits  = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      divisor   <= in_tone;
      remainder <= '0;
      quotient  <= prescaled_rate;
      tone_zero <= (in_tone == '0);
    end else if (cmd.div_step) begin
      remainder <= rem_fits ? rem_diff[sths_pkg::TONE_W-1:0]
                            : rem_shift[sths_pkg::TONE_W-1:0];
      quotient  <= {quotient[sths_pkg::RATE_W-2:0], rem_fits};
    end
  end

  assign quot_minus = quotient - sths_pkg::RATE_W'(1);

  always_comb begin
    if (tone_zero) begin
      period = '1;
    end else if (quotient == '0) begin
      period = '0;
    end else if (quot_minus[sths_pkg::RATE_W-1:sths_pkg::CMP_W] != '0) begin
      period = '1;
    end else begin
      period = quot_minus[sths_pkg::CMP_W-1:0];
    end
  end

  assign tick_load   = cmd.accept && !in_action;
  assign tick_match  = (tick_count == compare_value);
  assign do_step     = tick_match && enabled;
  assign pos_stepped = backward ? position - sths_pkg::POS_W'(1)
                                : position + sths_pkg::POS_W'(1);

  always_comb begin
    position_next = position;
    backward_next = backward;
    enabled_next  = enabled;
    if (cmd.commit) begin
      enabled_next = !tone_zero;
    end else if (tick_load && do_step) begin
      position_next = pos_stepped;
      if (pos_stepped >= travel_limit) begin
        backward_next = 1'b1;
      end else if (pos_stepped == '0) begin
        backward_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_value <= '1;
      tick_count    <= '0;
      position      <= '0;
      backward      <= 1'b0;
      enabled       <= 1'b0;
    end else begin
      position <= position_next;
      backward <= backward_next;
      enabled  <= enabled_next;
      if (cmd.commit) begin
        compare_value <= period;
        tick_count    <= '0;
      end else if (tick_load) begin
        tick_count <= tick_match ? '0 : tick_count + sths_pkg::CMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_load || cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_load || cmd.commit) begin
      out_step_pulse      <= tick_load && do_step;
      out_moving_backward <= backward_next;
      out_head_position   <= position_next;
      out_playing         <= enabled_next;
    end
  end

  assign stat.is_tone   = in_action;
  assign stat.tone_zero = (in_tone == '0);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

// ----- rtl/sths_ctrl.sv -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper controller
// Sequences item acceptance, the divide iterations and the tone commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stepper_tone_head_sweeper_unit_defines.svh"

module sths_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sths_pkg::ctrl_stat_t  stat,
  output sths_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } ctrl_state_t;

  ctrl_state_t                state;
  ctrl_state_t                state_next;
  logic [sths_pkg::CNT_W-1:0] div_count;
  logic                       div_last;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign div_last = (div_count == sths_pkg::DIV_LAST);

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.div_step = (state == S_DIV);
    cmd.commit   = (state == S_FIN) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && stat.is_tone) begin
          state_next = stat.tone_zero ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_count <= div_count + sths_pkg::CNT_W'(1);
      end else begin
        div_count <= '0;
      end
    end
  end

  `STHS_ASSERT(a_busy_not_ready, clk, rst, (state != S_IDLE) |-> !in_ready, "ready while busy")
  `STHS_ASSERT(a_tone_divides, clk, rst, (cmd.accept && stat.is_tone && !stat.tone_zero) |=> (state == S_DIV && div_count == '0), "divide not started")
  `STHS_ASSERT(a_div_ends, clk, rst, (state == S_DIV && div_last) |=> (state == S_FIN), "divide did not finish")
  `STHS_ASSERT(a_commit_idle, clk, rst, cmd.commit |=> (state == S_IDLE), "commit left block busy")

endmodule

// ----- rtl/stepper_tone_head_sweeper_unit.sv -----
// ---------------------------------------------------------------------------
// Stepper tone head sweeper unit
// Plays a tone by stepping a drive head back and forth on timer ticks.
// ---------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_ch    sink       action, tone
//  out_ch   source     step_pulse, moving_backward, head_position, playing
//  apb      slave      prescaled_rate (0x0), travel_limit (0x4)
//
// A tick transaction leaves the controller idle; the next item is taken once the output is free.
// A nonzero set-tone transaction runs the accept, 20 iterations of the
// radix-2 period divider, and the commit; a zero tone runs accept and commit.
// Reset is synchronous and leaves the head at zero, stopped, timer cleared.
// A stalled result holds in the output register and keeps the input from
// taking another item, or a set-tone from committing, until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stepper_tone_head_sweeper_unit (
  input  logic                          clk,
  input  logic                          rst,
  sths_in_if.sink                       in_ch,
  sths_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sths_pkg::ADDR_W-1:0]   paddr,
  input  logic [sths_pkg::DATA_W-1:0]   pwdata,
  output logic [sths_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  sths_pkg::ctrl_cmd_t  cmd;
  sths_pkg::ctrl_stat_t stat;

  assign pready = 1'b1;

  sths_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sths_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .in_action           (in_ch.action),
    .in_tone             (in_ch.tone),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_step_pulse      (out_ch.step_pulse),
    .out_moving_backward (out_ch.moving_backward),
    .out_head_position   (out_ch.head_position),
    .out_playing         (out_ch.playing),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata)
  );

endmodule
